FILE: rtl/core/ihd_pkg.sv
package ihd_pkg;

    // Number formats
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 18;
    localparam int GUARD_BITS  = 4;
    localparam int STATE_BITS  = SAMPLE_BITS + GUARD_BITS;
    localparam int ROM_BITS    = 28;

    // Section counts of the two polyphase branches
    localparam int N0 = 9;
    localparam int N1 = 10;

    // Section datapath widths: exact difference times a zero-extended coefficient
    localparam int PROD_BITS  = STATE_BITS + COEF_BITS + 2;
    localparam int ACC_BITS   = PROD_BITS - COEF_BITS + 1;
    localparam int ROUND_HALF = 1 << (COEF_BITS - 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [STATE_BITS-1:0]  t_state;
    typedef logic        [COEF_BITS:0]     t_coef;
    typedef logic        [ROM_BITS-1:0]    t_rom;

    // A sample moving from one allpass section to the next
    typedef struct packed {
        logic   valid;
        t_state data;
    } t_token;

    // Allpass coefficients in unsigned Q0.28
    localparam t_rom ROM_A0 [N0] = '{
        28'd20553852,  28'd70942732,  28'd128686529, 28'd177618835, 28'd212709103,
        28'd235603865, 28'd249873171, 28'd258775984, 28'd264757307
    };
    localparam t_rom ROM_A1 [N1] = '{
        28'd5345023,   28'd43407753,  28'd100182739, 28'd154794889, 28'd196880110,
        28'd225465036, 28'd243594487, 28'd254824106, 28'd262007493, 28'd267236176
    };

    // Round a Q0.28 constant half up to COEF_BITS fraction bits.
    function automatic t_coef coef_of(input t_rom q);
        logic [ROM_BITS:0] s;
        s = {1'b0, q} + ((ROM_BITS + 1)'(1) << (ROM_BITS - 1 - COEF_BITS));
        return s[ROM_BITS:ROM_BITS-COEF_BITS];
    endfunction

endpackage

FILE: rtl/core/ihd_cell.sv
module ihd_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ihd_pkg::t_coef  i_coef,
    input  ihd_pkg::t_token i_tok,
    output ihd_pkg::t_token o_tok
);
    import ihd_pkg::*;

    logic signed [STATE_BITS:0]     diff;
    logic signed [PROD_BITS-1:0]    prod;
    logic signed [PROD_BITS-1:0]    prod_rnd;
    logic signed [ACC_BITS-1:0]     acc;
    logic [ACC_BITS-STATE_BITS:0]   top_bits;
    t_state                         n_prev_out;
    logic                           r_valid;
    t_state                         r_prev_in;
    t_state                         r_prev_out;

    // Allpass section: y = a * (x - y_prev) + x_prev, product rounded half up.
    always_comb begin
        diff     = (STATE_BITS + 1)'($signed(i_tok.data)) - (STATE_BITS + 1)'(r_prev_out);
        prod     = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, i_coef}));
        prod_rnd = prod + PROD_BITS'(ROUND_HALF);
        acc      = ACC_BITS'($signed(prod_rnd[PROD_BITS-1:COEF_BITS]))
                 + ACC_BITS'(r_prev_in);
        top_bits = acc[ACC_BITS-1:STATE_BITS-1];
        // Saturate the section output to the state width.
        if ((&top_bits) || !(|top_bits)) begin
            n_prev_out = acc[STATE_BITS-1:0];
        end else if (acc[ACC_BITS-1]) begin
            n_prev_out = {1'b1, {(STATE_BITS - 1){1'b0}}};
        end else begin
            n_prev_out = {1'b0, {(STATE_BITS - 1){1'b1}}};
        end
    end

    // Section state is updated only when a sample passes through.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_prev_in  <= '0;
            r_prev_out <= '0;
        end else begin
            r_valid <= i_tok.valid;
            if (i_tok.valid) begin
                r_prev_in  <= i_tok.data;
                r_prev_out <= n_prev_out;
            end
        end
    end

    // The stored output is also the sample handed to the next section.
    assign o_tok.valid = r_valid;
    assign o_tok.data  = r_prev_out;

endmodule

FILE: rtl/core/ihd_out.sv
module ihd_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ihd_pkg::t_token  i_b0,
    input  ihd_pkg::t_token  i_b1,
    input  logic             i_ready,
    output logic             o_idle,
    output logic             o_valid,
    output ihd_pkg::t_sample o_sample_out
);
    import ihd_pkg::*;

    logic signed [STATE_BITS:0]              sum;
    t_state                                  half;
    logic [STATE_BITS-SAMPLE_BITS:0]         top_bits;
    t_sample                                 n_res;
    logic                                    move;
    t_state                                  r_s0;
    t_sample                                 r_hold;
    logic                                    r_hold_valid;
    t_sample                                 r_out;
    logic                                    r_out_valid;
    logic                                    r_busy;
    logic                                    n_hold_valid;
    logic                                    n_out_valid;
    logic                                    n_busy;

    // Half the branch sum, rounded half up, saturated to the sample width.
    always_comb begin
        sum      = (STATE_BITS + 1)'(r_s0) + (STATE_BITS + 1)'($signed(i_b1.data))
                 + (STATE_BITS + 1)'(1);
        half     = sum[STATE_BITS:1];
        top_bits = half[STATE_BITS-1:SAMPLE_BITS-1];
        if ((&top_bits) || !(|top_bits)) begin
            n_res = half[SAMPLE_BITS-1:0];
        end else if (half[STATE_BITS-1]) begin
            n_res = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        end else begin
            n_res = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        end
    end

    // Hold stage feeds the output register when that is free or being drained.
    always_comb begin
        move         = r_hold_valid && (!r_out_valid || i_ready);
        n_hold_valid = r_hold_valid;
        n_out_valid  = r_out_valid;
        n_busy       = r_busy;
        if (i_b1.valid) begin
            n_hold_valid = 1'b1;
        end else if (move) begin
            n_hold_valid = 1'b0;
        end
        if (move) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_start) begin
            n_busy = 1'b1;
        end else if (move) begin
            n_busy = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_busy       <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
            r_busy       <= n_busy;
        end
    end

    // Data registers
    always_ff @(posedge i_clk) begin
        if (i_b0.valid) begin
            r_s0 <= i_b0.data;
        end
        if (i_b1.valid) begin
            r_hold <= n_res;
        end
        if (move) begin
            r_out <= r_hold;
        end
    end

    assign o_idle       = !r_busy;
    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out;

    // Branch 0 is one section shorter, so its result arrives in the cycle before that of branch 1.
    a_b0_leads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_b0.valid |=> i_b1.valid)
        else $error("branch 0 result not followed by branch 1 result");

    // A branch result only arrives while a request is in flight and the hold is empty.
    a_b1_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_b1.valid |-> (r_busy && !r_hold_valid))
        else $error("branch 1 result arrived with no free hold stage");

    // A waiting result keeps the block busy.
    a_hold_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> r_busy)
        else $error("hold stage full while block idle");

    // No new request starts while the chains are still at work.
    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (!r_busy && !i_b0.valid && !i_b1.valid))
        else $error("request accepted while busy");

endmodule

FILE: rtl/core/iir_halfband_decimator.sv
// Halfband decimator by two: two polyphase branches of first-order allpass
// sections, 9 for the earlier sample and 10 for the later one.
// Input channel: i_valid / o_ready carry one pair of consecutive 2x-rate
// samples (i_sample_early, i_sample_late), signed Q1.23.
// Output channel: o_valid / i_ready carry one decimated sample o_sample_out,
// signed Q1.23, rounded and saturated.
// After a request is accepted, the first cell loads at the accepting edge, then
// the rest of the 10-cell chain of the later branch, a hold stage and an output
// stage follow before o_valid rises.
// A request is taken only when o_ready comes back, which happens together with
// o_valid, so no new request enters while one is in the chains. Each cell of a
// chain advances the sample by one section per cycle.
// A new request is accepted while the previous result still waits in the
// output register. If the receiver keeps stalling, the next result parks in
// the hold stage and o_ready stays low until the output register frees up.
// Reset clears all section states to zero and empties the hold and output
// stages; o_ready is high right after reset.
module iir_halfband_decimator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ihd_pkg::t_sample i_sample_early,
    input  ihd_pkg::t_sample i_sample_late,
    output logic             o_valid,
    input  logic             i_ready,
    output ihd_pkg::t_sample o_sample_out
);
    import ihd_pkg::*;

    logic   accept;
    logic   idle;
    t_token b0_tok [N0+1];
    t_token b1_tok [N1+1];

    assign o_ready = idle;
    assign accept  = i_valid && idle;

    // Samples enter the first cell of each branch sign-extended to the state width.
    assign b0_tok[0].valid = accept;
    assign b0_tok[0].data  = STATE_BITS'(i_sample_early);
    assign b1_tok[0].valid = accept;
    assign b1_tok[0].data  = STATE_BITS'(i_sample_late);

    // Branch 0 section chain
    for (genvar g = 0; g < N0; g++) begin : g_b0
        ihd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_coef  (coef_of(ROM_A0[g])),
            .i_tok   (b0_tok[g]),
            .o_tok   (b0_tok[g+1])
        );
    end

    // Branch 1 section chain
    for (genvar g = 0; g < N1; g++) begin : g_b1
        ihd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_coef  (coef_of(ROM_A1[g])),
            .i_tok   (b1_tok[g]),
            .o_tok   (b1_tok[g+1])
        );
    end

    // Branch sum, output stage and request tracking
    ihd_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (accept),
        .i_b0         (b0_tok[N0]),
        .i_b1         (b1_tok[N1]),
        .i_ready      (i_ready),
        .o_idle       (idle),
        .o_valid      (o_valid),
        .o_sample_out (o_sample_out)
    );

endmodule

FILE: dv/testbench.sv
module testbench;

    import ihd_pkg::*;

    // Stimulus flavors for the random part, chosen per run of 16 requests.
    typedef enum logic [1:0] {
        MIX_UNIFORM,
        MIX_EXTREME,
        MIX_SMALL,
        MIX_NYQUIST
    } t_mix;

    typedef struct {
        t_sample early;
        t_sample late;
    } t_pair;

    localparam t_sample SMP_MAX = t_sample'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam t_sample SMP_MIN = t_sample'(1 << (SAMPLE_BITS - 1));
    localparam int unsigned RANDOM_PAIRS = 500;
    localparam int unsigned IDLE_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES = 30;

    // Allpass coefficients of both branches in unsigned Q0.28; branch 0 has one unused slot.
    localparam longint COEF_Q28 [2][N1] = '{
        '{20553852, 70942732, 128686529, 177618835, 212709103,
          235603865, 249873171, 258775984, 264757307, 0},
        '{5345023, 43407753, 100182739, 154794889, 196880110,
          225465036, 243594487, 254824106, 262007493, 267236176}
    };

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    o_ready;
    t_sample i_sample_early = '0;
    t_sample i_sample_late = '0;
    logic    o_valid;
    logic    i_ready = 1'b0;
    t_sample o_sample_out;

    // Last input and last output of every allpass section, per branch.
    t_state section_in [2][N1];
    t_state section_out [2][N1];

    t_pair   pair_queue [$];
    t_sample decimated_q [$];

    int unsigned pairs_sent = 0;
    int unsigned samples_checked = 0;
    int unsigned mismatches = 0;
    int unsigned output_clips = 0;
    int unsigned section_clips = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned idle_cycles = 0;

    iir_halfband_decimator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_early (i_sample_early),
        .i_sample_late  (i_sample_late),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample_out   (o_sample_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp_signed(input longint v, input int bits);
        longint top;
        top = (longint'(1) << (bits - 1)) - 1;
        if (v > top) return top;
        if (v < -top - 1) return -top - 1;
        return v;
    endfunction

    // Every third stretch of 40 requests runs without any wait states.
    function automatic int unsigned draw_wait(input int unsigned count);
        if ((count / 40) % 3 == 1) return 0;
        return $urandom_range(0, 7);
    endfunction

    // Push one sample through the allpass chain of a branch and update its state.
    task automatic run_branch(input int b, input longint x, output longint y);
        int k;
        int sections;
        longint coef;
        longint raw;
        sections = (b == 0) ? N0 : N1;
        y = x;
        for (k = 0; k < sections; k++) begin
            coef = (COEF_Q28[b][k] + (longint'(1) << (27 - COEF_BITS))) >>> (28 - COEF_BITS);
            raw = (((x - longint'(section_out[b][k])) * coef + ROUND_HALF) >>> COEF_BITS)
                  + longint'(section_in[b][k]);
            y = clamp_signed(raw, STATE_BITS);
            if (y != raw) section_clips++;
            section_in[b][k] = t_state'(x);
            section_out[b][k] = t_state'(y);
            x = y;
        end
    endtask

    // One decimated sample: half the sum of both branch outputs, rounded and saturated.
    task automatic predict_decimated(input t_sample early, input t_sample late,
                                     output t_sample result);
        longint s0;
        longint s1;
        longint half;
        longint sat;
        run_branch(0, longint'(early), s0);
        run_branch(1, longint'(late), s1);
        half = (s0 + s1 + 1) >>> 1;
        sat = clamp_signed(half, SAMPLE_BITS);
        if (sat != half) output_clips++;
        result = t_sample'(sat);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic add_pair(input t_sample early, input t_sample late);
        t_pair p;
        p.early = early;
        p.late = late;
        pair_queue.push_back(p);
    endtask

    // Request driver: predicts on acceptance, then waits a drawn gap before the next one.
    always @(posedge i_clk) begin
        t_pair p;
        t_sample want;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_wait <= 0;
        end else begin
            if (i_valid && o_ready) begin
                predict_decimated(i_sample_early, i_sample_late, want);
                decimated_q.push_back(want);
                pairs_sent <= pairs_sent + 1;
            end
            if (!i_valid || o_ready) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    i_valid <= 1'b0;
                end else if (pair_queue.size() != 0) begin
                    p = pair_queue.pop_front();
                    i_sample_early <= p.early;
                    i_sample_late <= p.late;
                    i_valid <= 1'b1;
                    send_wait <= draw_wait(pairs_sent);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each sample against the oldest prediction, stalls at random.
    always @(posedge i_clk) begin
        t_sample want;
        int unsigned stall;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_wait <= 0;
        end else if (o_valid && i_ready) begin
            if (decimated_q.size() == 0) begin
                report_mismatch($sformatf("unexpected sample_out %0d", o_sample_out));
            end else begin
                want = decimated_q.pop_front();
                if (o_sample_out !== want)
                    report_mismatch($sformatf("sample_out %0d, expected %0d (result %0d)",
                                              o_sample_out, want, samples_checked));
            end
            samples_checked <= samples_checked + 1;
            stall = draw_wait(samples_checked);
            recv_wait <= stall;
            i_ready <= (stall == 0);
        end else if (!i_ready) begin
            if (recv_wait <= 1) begin
                recv_wait <= 0;
                i_ready <= 1'b1;
            end else begin
                recv_wait <= recv_wait - 1;
            end
        end
    end

    // Watchdog: too long without any request or result moving ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int b;
        int k;
        int unsigned n;
        t_mix mix;
        t_sample amp;

        for (b = 0; b < 2; b++)
            for (k = 0; k < N1; k++) begin
                section_in[b][k] = '0;
                section_out[b][k] = '0;
            end

        // Directed: zero, field extremes, small signs, and full-scale steps and
        // alternation that drive the output into saturation.
        add_pair('0, '0);
        add_pair(SMP_MAX, SMP_MIN);
        add_pair(SMP_MIN, SMP_MAX);
        add_pair(t_sample'(1), t_sample'(-1));
        add_pair(t_sample'(-1), t_sample'(1));
        add_pair(t_sample'(24'h555555), t_sample'(24'hAAAAAA));
        add_pair(t_sample'(24'hAAAAAA), t_sample'(24'h555555));
        for (n = 0; n < 4; n++) add_pair(SMP_MIN, SMP_MIN);
        for (n = 0; n < 5; n++) add_pair(SMP_MAX, SMP_MAX);
        for (n = 0; n < 4; n++) add_pair(SMP_MAX, SMP_MIN);
        for (n = 0; n < 4; n++) add_pair(SMP_MIN, SMP_MAX);

        // Random: runs of one flavor so that the filter state builds up.
        for (n = 0; n < RANDOM_PAIRS; n++) begin
            if (n % 16 == 0) mix = t_mix'($urandom_range(0, 3));
            case (mix)
                MIX_UNIFORM: begin
                    add_pair(t_sample'($urandom), t_sample'($urandom));
                end
                MIX_EXTREME: begin
                    add_pair($urandom_range(0, 1) ? SMP_MAX : SMP_MIN,
                             $urandom_range(0, 1) ? SMP_MAX : SMP_MIN);
                end
                MIX_SMALL: begin
                    add_pair(t_sample'(int'($urandom_range(0, 64)) - 32),
                             t_sample'(int'($urandom_range(0, 64)) - 32));
                end
                default: begin
                    amp = t_sample'($urandom);
                    add_pair(amp, -amp);
                end
            endcase
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pair_queue.size() != 0 || i_valid || decimated_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d sample pairs and checked %0d decimated samples.",
                 pairs_sent, samples_checked);
        $display("Saturation seen: %0d output samples, %0d section outputs; %0d mismatches.",
                 output_clips, section_clips, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ihd_pkg.sv
rtl/core/ihd_cell.sv
rtl/core/ihd_out.sv
rtl/core/iir_halfband_decimator.sv
dv/testbench.sv
